>>> hdl/pidwc_pkg.sv
package pidwc_pkg;

    localparam int DW        = 32;
    localparam int PW        = 2 * DW;
    localparam int SAT_W     = 2 * DW + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_SPEED = 2'd0;
    localparam logic [1:0] MODE_ANGLE = 2'd1;
    localparam logic [1:0] MODE_INCR  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_WRAP,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D,
        CFG_DRIVE_LIM,
        CFG_INTEGRAL_MAX
    } t_cfg_idx;

    typedef logic signed [DW-1:0]    t_data;
    typedef logic [DW-2:0]           t_mag;
    typedef logic signed [PW-1:0]    t_prod;
    typedef logic signed [SAT_W-1:0] t_sat;

    typedef struct packed {
        logic [1:0] mode;
        logic       wrap_radians;
        t_data      gain_p;
        t_data      gain_i;
        t_data      gain_d;
        t_mag       drive_lim;
        t_mag       integral_max;
    } t_cfg;

    typedef struct packed {
        t_data measured;
        t_data target;
    } t_in_beat;

    typedef struct packed {
        t_data drive;
    } t_out_beat;

    typedef struct packed {
        t_data op_p;
        t_data op_i;
        t_data op_d;
    } t_ops;

    localparam t_sat DMAX_W = t_sat'((longint'(1) << (DW - 1)) - longint'(1));
    localparam t_sat DMIN_W = -DMAX_W - t_sat'(1);

    function automatic t_data sat_dw(input t_sat x);
        t_data r;
        if (x > DMAX_W) begin
            r = DMAX_W[DW-1:0];
        end else if (x < DMIN_W) begin
            r = DMIN_W[DW-1:0];
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

    function automatic t_data clamp_sym(input t_sat x, input t_mag m);
        t_sat  mx;
        t_sat  nmx;
        t_data r;
        mx  = t_sat'($signed({1'b0, m}));
        nmx = -mx;
        if (x > mx) begin
            r = mx[DW-1:0];
        end else if (x < nmx) begin
            r = nmx[DW-1:0];
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/pidwc_stream_if.sv
interface pidwc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pidwc_unwrap.sv
module pidwc_unwrap #(
    parameter int FRAC_BITS    = 16,
    parameter int ENCODER_SPAN = 8192
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  pidwc_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    input  pidwc_pkg::t_in_beat i_beat,
    output logic                o_valid,
    output pidwc_pkg::t_data    o_err
);
    import pidwc_pkg::*;

    localparam int SPAN_BITS = $clog2(ENCODER_SPAN + 1) + FRAC_BITS + 1;
    localparam int WW        = ((SPAN_BITS > DW) ? SPAN_BITS : DW) + 4;

    localparam longint HALF_L  = longint'(ENCODER_SPAN / 2) << FRAC_BITS;
    localparam longint FULL_L  = longint'(ENCODER_SPAN) << FRAC_BITS;
    localparam longint PI_Q24  = 64'sd52707179;
    localparam longint TPI_Q24 = 64'sd105414358;
    localparam int     PI_SH   = 24 - FRAC_BITS;
    localparam longint PI_L    = (PI_SH > 0) ?
        ((PI_Q24 + (longint'(1) << (PI_SH - 1))) >>> PI_SH) : PI_Q24;
    localparam longint TPI_L   = (PI_SH > 0) ?
        ((TPI_Q24 + (longint'(1) << (PI_SH - 1))) >>> PI_SH) : TPI_Q24;

    typedef logic signed [WW-1:0] t_wide;

    localparam t_wide HALF = t_wide'(HALF_L);
    localparam t_wide FULL = t_wide'(FULL_L);
    localparam t_wide PI   = t_wide'(PI_L);
    localparam t_wide TPI  = t_wide'(TPI_L);

    logic  r_u_v;
    t_wide r_meas;
    t_data r_targ;
    logic  r_e_v;
    t_data r_err;

    t_wide m0;
    t_wide t0;
    t_wide m1;
    t_wide m2;
    t_wide n_meas;
    t_wide t1;
    t_wide m3;
    t_wide m4;
    t_wide diff;
    t_data n_err;
    logic  wrap_on;

    // encoder span unwrap; incremental mode bypasses
    always_comb begin
        m0 = t_wide'(i_beat.measured);
        t0 = t_wide'(i_beat.target);
        m1 = ((t0 - m0) > HALF) ? (m0 + FULL) : m0;
        m2 = ((m1 - t0) > HALF) ? (m1 - FULL) : m1;
        n_meas = (i_cfg.mode == MODE_INCR) ? m0 : m2;
    end

    // radian unwrap and error
    always_comb begin
        wrap_on = i_cfg.wrap_radians && (i_cfg.mode != MODE_INCR);
        t1 = t_wide'(r_targ);
        m3 = (wrap_on && ((t1 - r_meas) > PI)) ? (r_meas + TPI) : r_meas;
        m4 = (wrap_on && ((m3 - t1) > PI)) ? (m3 - TPI) : m3;
        diff = (i_cfg.mode == MODE_SPEED) ? ((t1 <<< 1) - m4) : (t1 - m4);
        n_err = sat_dw(t_sat'(diff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_adv) begin
            r_u_v <= i_valid;
            r_e_v <= r_u_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_meas <= n_meas;
            r_targ <= i_beat.target;
            r_err  <= n_err;
        end
    end

    assign o_valid = r_e_v;
    assign o_err   = r_err;

endmodule

>>> hdl/pidwc_state.sv
module pidwc_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  pidwc_pkg::t_cfg  i_cfg,
    input  logic             i_valid,
    input  pidwc_pkg::t_data i_err,
    output logic             o_valid,
    output pidwc_pkg::t_ops  o_ops
);
    import pidwc_pkg::*;

    t_data r_sum;
    t_data r_prev;
    t_data r_dprev;
    logic  r_op_v;
    t_ops  r_ops;

    t_data n_sum;
    t_data d1;
    t_data d2;
    t_ops  n_ops;
    logic  incr;
    logic  fire;

    always_comb begin
        incr  = (i_cfg.mode == MODE_INCR);
        fire  = i_adv && i_valid;
        n_sum = clamp_sym(t_sat'(r_sum) + t_sat'(i_err), i_cfg.integral_max);
        d1    = sat_dw(t_sat'(i_err) - t_sat'(r_prev));
        d2    = sat_dw(t_sat'(i_err) - t_sat'(r_prev) - t_sat'(r_dprev));
        if (incr) begin
            n_ops.op_p = d1;
            n_ops.op_i = i_err;
            n_ops.op_d = d2;
        end else begin
            n_ops.op_p = i_err;
            n_ops.op_i = n_sum;
            n_ops.op_d = d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_prev  <= '0;
            r_dprev <= '0;
            r_op_v  <= 1'b0;
        end else begin
            if (i_adv) begin
                r_op_v <= i_valid;
            end
            if (fire) begin
                r_prev <= i_err;
                if (incr) begin
                    r_dprev <= d1;
                end else begin
                    r_sum <= n_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ops <= n_ops;
        end
    end

    assign o_valid = r_op_v;
    assign o_ops   = r_ops;

    logic signed [DW-1:0] imax_s;
    assign imax_s = $signed({1'b0, i_cfg.integral_max});

    a_incr_keeps_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && incr) |=> $stable(r_sum))
        else $error("error sum moved in incremental mode");

    a_pos_keeps_dprev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !incr) |=> $stable(r_dprev))
        else $error("delta history moved in positional mode");

    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !incr) |=> ((r_sum <= $past(imax_s)) && (r_sum >= -$past(imax_s))))
        else $error("error sum outside integral limit");

endmodule

>>> hdl/pidwc_mult.sv
module pidwc_mult #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  pidwc_pkg::t_cfg  i_cfg,
    input  logic             i_valid,
    input  pidwc_pkg::t_ops  i_ops,
    output logic             o_valid,
    output pidwc_pkg::t_data o_drive
);
    import pidwc_pkg::*;

    localparam t_sat BIAS = t_sat'((longint'(1) << FRAC_BITS) - longint'(1));

    function automatic t_data scale_q(input t_prod p);
        t_sat x;
        x = t_sat'(p);
        if (p[PW-1]) begin
            x = x + BIAS;
        end
        x = x >>> FRAC_BITS;
        return sat_dw(x);
    endfunction

    logic  r_m_v;
    t_prod r_prod_p;
    t_prod r_prod_i;
    t_prod r_prod_d;
    logic  r_o_v;
    t_data r_drive;

    t_prod n_prod_p;
    t_prod n_prod_i;
    t_prod n_prod_d;
    t_sat  total;
    t_data n_drive;

    always_comb begin
        n_prod_p = t_prod'(i_cfg.gain_p) * t_prod'(i_ops.op_p);
        n_prod_i = t_prod'(i_cfg.gain_i) * t_prod'(i_ops.op_i);
        n_prod_d = t_prod'(i_cfg.gain_d) * t_prod'(i_ops.op_d);
    end

    always_comb begin
        total = t_sat'(scale_q(r_prod_p)) + t_sat'(scale_q(r_prod_i))
              + t_sat'(scale_q(r_prod_d));
        n_drive = clamp_sym(total, i_cfg.drive_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_adv) begin
            r_m_v <= i_valid;
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_drive  <= n_drive;
        end
    end

    assign o_valid = r_o_v;
    assign o_drive = r_drive;

    logic signed [DW-1:0] omax_s;
    assign omax_s = $signed({1'b0, i_cfg.drive_lim});

    a_drive_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_m_v) |=> ((r_drive <= $past(omax_s)) && (r_drive >= -$past(omax_s))))
        else $error("drive outside output limit");

endmodule

>>> hdl/pid_controller_wrap_clamp_core.sv
// Each beat is registered in turn by the input register, encoder unwrap,
// radian unwrap and error, integral state, gain multipliers, and sum and clamp.
// Throughput: one beat per cycle; a stalled result holds every stage.
// Reset clears configuration, error history and all valid flags.
module pid_controller_wrap_clamp_core #(
    parameter int FRAC_BITS    = 16,
    parameter int ENCODER_SPAN = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pidwc_stream_if.sink                        i_in,
    pidwc_stream_if.source                      o_out,
    input  logic                                i_cfg_we,
    input  logic [pidwc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidwc_pkg::DW-1:0]            i_cfg_data
);
    import pidwc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    logic     r_in_v;
    t_in_beat r_in;

    logic     adv;
    logic     err_v;
    t_data    err;
    logic     ops_v;
    t_ops     ops;
    logic     out_v;
    t_data    drive;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:         n_cfg.mode         = i_cfg_data[1:0];
                CFG_WRAP:         n_cfg.wrap_radians = i_cfg_data[0];
                CFG_GAIN_P:       n_cfg.gain_p       = i_cfg_data;
                CFG_GAIN_I:       n_cfg.gain_i       = i_cfg_data;
                CFG_GAIN_D:       n_cfg.gain_d       = i_cfg_data;
                CFG_DRIVE_LIM:    n_cfg.drive_lim    = i_cfg_data[DW-2:0];
                CFG_INTEGRAL_MAX: n_cfg.integral_max = i_cfg_data[DW-2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // whole pipeline moves unless the output beat is stuck
    assign adv        = !out_v || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (adv) begin
            r_in_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    pidwc_unwrap #(
        .FRAC_BITS    (FRAC_BITS),
        .ENCODER_SPAN (ENCODER_SPAN)
    ) u_unwrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_valid (r_in_v),
        .i_beat  (r_in),
        .o_valid (err_v),
        .o_err   (err)
    );

    pidwc_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_valid (err_v),
        .i_err   (err),
        .o_valid (ops_v),
        .o_ops   (ops)
    );

    pidwc_mult #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_valid (ops_v),
        .i_ops   (ops),
        .o_valid (out_v),
        .o_drive (drive)
    );

    assign o_out.valid = out_v;
    assign o_out.data  = t_out_beat'{drive: drive};

endmodule
